// ===== rtl/suvs_pkg.sv =====
package suvs_pkg;

  localparam int unsigned CAPACITY = 32;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 6;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LIST   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_ELEMENT   = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

endpackage

// ===== rtl/suvs_ram.sv =====
module suvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_unique_value_set_unit.sv =====
// sorted set of distinct signed 32-bit values, kept ascending in one ram
//
// input stream s_axis: one transaction per command (insert, delete, clear,
// list). output stream m_axis: one result per command, or for list one
// result per stored value in ascending order with tlast on the final one
// (a single "empty" result when nothing is stored).
//
// commands are handled one at a time; s_axis_tready is high only while idle.
// each search step reads one stored entry and compares it; each moved
// entry is read and written back one slot over; the ram read is registered.
// the next command is taken in the cycle after the last result is loaded.
//
// reset empties the set (count goes to zero); ram contents are not cleared.
// a finished result waits in the output register while m_axis_tready is
// low; the block still takes the next command, and only stalls when it has
// another result to hand over.
module sorted_unique_value_set_unit #(
  parameter int unsigned CAPACITY = suvs_pkg::CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // kind [1:0], value [33:2], zero fill [39:34]
  input  logic [suvs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [2:0], value_out [34:3], count [40:35], zero fill [47:41]
  output logic [suvs_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);

  import suvs_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_SHRD,
    S_SHWR,
    S_INSWR,
    S_EMIT,
    S_LRD,
    S_LOUT
  } state_e;

  state_e                   state_q;
  kind_e                    op_q;
  logic signed [ValueW-1:0] value_q;
  status_e                  status_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            idx_q;
  logic [CW-1:0]            pos_q;

  logic                     m_valid_q;
  status_e                  m_status_q;
  logic [ValueW-1:0]        m_value_q;
  logic                     m_last_q;
  logic [CountW-1:0]        m_count_q;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ValueW-1:0]        ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [ValueW-1:0]        ram_rdata;

  logic [CW-1:0]            idx_m1;
  logic [CW-1:0]            idx_p1;
  logic                     out_free;
  logic                     out_load;
  kind_e                    in_kind;
  logic signed [ValueW-1:0] in_value;

  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = out_free && (state_q == S_EMIT || state_q == S_LOUT);
  assign in_kind  = kind_e'(s_axis_tdata[1:0]);
  assign in_value = s_axis_tdata[33:2];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {7'd0, m_count_q, m_value_q, m_status_q};

  suvs_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    unique case (state_q)
      S_SRD: begin
        ram_re = (idx_q != count_q);
      end
      S_SHRD: begin
        if (op_q == KIND_INSERT) begin
          ram_re    = (idx_q != pos_q);
          ram_raddr = idx_m1[AW-1:0];
        end else begin
          ram_re    = (idx_p1 != count_q);
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      S_SHWR: begin
        ram_we = 1'b1;
      end
      S_INSWR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = value_q;
      end
      S_LRD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= in_kind;
            value_q <= (in_kind == KIND_INSERT || in_kind == KIND_DELETE) ? in_value : '0;
            idx_q   <= '0;
            unique case (in_kind)
              KIND_INSERT, KIND_DELETE: begin
                state_q <= S_SRD;
              end
              KIND_CLEAR: begin
                count_q  <= '0;
                status_q <= ST_CLEARED;
                state_q  <= S_EMIT;
              end
              KIND_LIST: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_EMIT;
                end else begin
                  state_q <= S_LRD;
                end
              end
            endcase
          end
        end
        S_SRD: begin
          if (idx_q == count_q) begin
            // ran past the stored values
            if (op_q == KIND_INSERT) begin
              pos_q <= idx_q;
              if (count_q == CapCount) begin
                status_q <= ST_FULL;
                state_q  <= S_EMIT;
              end else begin
                state_q <= S_SHRD;
              end
            end else begin
              status_q <= ST_NOT_FOUND;
              state_q  <= S_EMIT;
            end
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (ram_rdata == value_q) begin
            if (op_q == KIND_INSERT) begin
              status_q <= ST_DUPLICATE;
              state_q  <= S_EMIT;
            end else begin
              state_q <= S_SHRD;
            end
          end else if (op_q == KIND_INSERT && $signed(ram_rdata) > value_q) begin
            pos_q <= idx_q;
            if (count_q == CapCount) begin
              status_q <= ST_FULL;
              state_q  <= S_EMIT;
            end else begin
              idx_q   <= count_q;
              state_q <= S_SHRD;
            end
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_SRD;
          end
        end
        S_SHRD: begin
          if (op_q == KIND_INSERT) begin
            // move entries up from the top down to the insert position
            state_q <= (idx_q == pos_q) ? S_INSWR : S_SHWR;
          end else if (idx_p1 == count_q) begin
            count_q  <= count_q - 1'b1;
            status_q <= ST_DELETED;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx_q   <= (op_q == KIND_INSERT) ? idx_m1 : idx_p1;
          state_q <= S_SHRD;
        end
        S_INSWR: begin
          count_q  <= count_q + 1'b1;
          status_q <= ST_INSERTED;
          state_q  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_status_q <= status_q;
            m_value_q  <= value_q;
            m_last_q   <= 1'b1;
            m_count_q  <= CountW'(count_q);
            state_q    <= S_IDLE;
          end
        end
        S_LRD: begin
          state_q <= S_LOUT;
        end
        S_LOUT: begin
          if (out_free) begin
            m_status_q <= ST_ELEMENT;
            m_value_q  <= ram_rdata;
            m_last_q   <= (idx_p1 == count_q);
            m_count_q  <= CountW'(count_q);
            idx_q      <= idx_p1;
            state_q    <= (idx_p1 == count_q) ? S_IDLE : S_LRD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
